[rtl/gwp_pkg.sv]
`default_nettype none

package gwp_pkg;

    localparam int FRAC_BITS_DEF       = 16;
    localparam int MAX_FRAC_DIGITS_DEF = 6;
    localparam int NUM_LETTERS         = 16;

    // Letter codes of the word alphabet.
    localparam logic [3:0] LTR_G = 4'd0;
    localparam logic [3:0] LTR_M = 4'd1;
    localparam logic [3:0] LTR_T = 4'd2;
    localparam logic [3:0] LTR_S = 4'd3;
    localparam logic [3:0] LTR_P = 4'd4;
    localparam logic [3:0] LTR_X = 4'd5;
    localparam logic [3:0] LTR_Y = 4'd6;
    localparam logic [3:0] LTR_Z = 4'd7;
    localparam logic [3:0] LTR_I = 4'd8;
    localparam logic [3:0] LTR_J = 4'd9;
    localparam logic [3:0] LTR_D = 4'd10;
    localparam logic [3:0] LTR_H = 4'd11;
    localparam logic [3:0] LTR_F = 4'd12;
    localparam logic [3:0] LTR_E = 4'd13;
    localparam logic [3:0] LTR_R = 4'd14;
    localparam logic [3:0] LTR_N = 4'd15;

    localparam logic KIND_WORD    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_line;
    } in_beat_t;

    typedef struct packed {
        logic               kind;
        logic [3:0]         letter;
        logic signed [47:0] word_value;
        logic [15:0]        seen_mask;
        logic               has_command;
        logic               last;
    } out_beat_t;

    typedef struct packed {
        logic       found;
        logic [3:0] code;
    } letter_hit_t;

    function automatic letter_hit_t find_letter(input logic [7:0] c);
        logic [7:0]  u;
        letter_hit_t hit;
        u = (c >= 8'h61 && c <= 8'h7a) ? (c - 8'd32) : c;
        hit.found = 1'b1;
        hit.code  = LTR_G;
        case (u)
            8'h47:   hit.code = LTR_G;
            8'h4d:   hit.code = LTR_M;
            8'h54:   hit.code = LTR_T;
            8'h53:   hit.code = LTR_S;
            8'h50:   hit.code = LTR_P;
            8'h58:   hit.code = LTR_X;
            8'h59:   hit.code = LTR_Y;
            8'h5a:   hit.code = LTR_Z;
            8'h49:   hit.code = LTR_I;
            8'h4a:   hit.code = LTR_J;
            8'h44:   hit.code = LTR_D;
            8'h48:   hit.code = LTR_H;
            8'h46:   hit.code = LTR_F;
            8'h45:   hit.code = LTR_E;
            8'h52:   hit.code = LTR_R;
            8'h4e:   hit.code = LTR_N;
            default: hit.found = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic is_fixed_letter(input logic [3:0] code);
        return (code == LTR_X) || (code == LTR_Y) || (code == LTR_Z) ||
               (code == LTR_F) || (code == LTR_E);
    endfunction

    function automatic logic [31:0] pow10(input logic [3:0] n);
        logic [31:0] p;
        case (n)
            4'd0:    p = 32'd1;
            4'd1:    p = 32'd10;
            4'd2:    p = 32'd100;
            4'd3:    p = 32'd1000;
            4'd4:    p = 32'd10000;
            4'd5:    p = 32'd100000;
            4'd6:    p = 32'd1000000;
            4'd7:    p = 32'd10000000;
            4'd8:    p = 32'd100000000;
            default: p = 32'd1000000000;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

[rtl/gcode_word_parser.sv]
// G-code word parser.
// Input channel (s_valid/s_ready/s_data): one character of a command line per beat,
// with end_of_line set on the line's final character. Result channel
// (m_valid/m_ready/m_data): word results (kind 0) carrying letter code and value,
// and one summary (kind 1) per line with the mask of letters seen and has_command.
// One character causes up to three results; last marks the final one of them.
// A character that continues a word passes S_CHAR and S_EOL, one that starts a word
// passes S_CHAR, S_LETTER and S_EOL, before s_ready returns in S_IDLE.
// Closing an integer word passes S_FIN and S_EMIT, where the output hand-off
// waits; closing an X, Y, Z, F or E word also passes S_DIV and S_ADD, where the
// restoring divider scales the decimal fraction one quotient bit per cycle.
// Results leave through a single output register, so a waiting result does not
// block the next character; the sequencer stalls only when it must place a new
// result while the register is still full and m_ready is low.
// Reset (aresetn low, synchronous) empties the output register and clears the
// line state: no word open, no letters seen.
`default_nettype none

module gcode_word_parser
    import gwp_pkg::*;
#(
    parameter int FRAC_BITS       = FRAC_BITS_DEF,
    parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_beat_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_beat_t      m_data
);

    localparam int ACC_W  = 40;
    localparam int FRAC_W = $clog2(pow10(4'(MAX_FRAC_DIGITS)));
    localparam int P_W    = $clog2(pow10(4'(MAX_FRAC_DIGITS)) + 1);
    localparam int R_W    = P_W + 1;
    localparam int DIG_W  = $clog2(MAX_FRAC_DIGITS + 1);
    localparam int CNT_W  = $clog2(FRAC_BITS + 1);
    localparam int Q_W    = FRAC_BITS + 1;
    localparam int HI_LSB = 47 - FRAC_BITS;

    localparam logic [ACC_W-1:0] ACC_CAP = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [47:0] LIM_FIX_POS = {1'b0, {47{1'b1}}};
    localparam logic [47:0] LIM_FIX_NEG = {1'b1, {47{1'b0}}};
    localparam logic [47:0] LIM_INT_POS = {17'd0, {31{1'b1}}};
    localparam logic [47:0] LIM_INT_NEG = {16'd0, 1'b1, 31'd0};

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_POINT = 8'h2e;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [3:0] {
        S_IDLE, S_CHAR, S_LETTER, S_EOL, S_FIN, S_DIV, S_ADD, S_EMIT, S_SUM
    } state_t;

    typedef enum logic [2:0] {
        PH_IDLE, PH_PRE, PH_SIGNED, PH_INT, PH_FRAC
    } phase_t;

    state_t            state_reg;
    logic              m_valid_reg;
    out_beat_t         m_data_reg;

    logic [7:0]        char_reg;
    logic              eol_reg;
    logic              from_eol_reg;

    logic              active_reg;
    logic [3:0]        letter_reg;
    phase_t            phase_reg;
    logic              neg_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [FRAC_W-1:0] frac_reg;
    logic [DIG_W-1:0]  dig_reg;
    logic [15:0]       seen_reg;

    logic [P_W-1:0]       p_reg;
    logic [R_W-1:0]       div_rem_reg;
    logic [FRAC_BITS-1:0] div_low_reg;
    logic [Q_W-1:0]       quot_reg;
    logic [CNT_W-1:0]     div_cnt_reg;
    logic [47:0]          mag_reg;
    logic                 sat_reg;

    // Character classes of the held character.
    logic        is_digit;
    logic        is_blank;
    logic        is_sign;
    logic [3:0]  digit;
    logic        fixed;
    letter_hit_t hit;

    assign is_digit = (char_reg >= CH_ZERO) && (char_reg <= CH_NINE);
    assign is_blank = (char_reg == CH_SPACE) || (char_reg == CH_TAB);
    assign is_sign  = (char_reg == CH_PLUS) || (char_reg == CH_MINUS);
    assign digit    = char_reg[3:0];
    assign fixed    = is_fixed_letter(letter_reg);
    assign hit      = find_letter(char_reg);

    // Accumulator steps: value * 10 + digit as two shifted adds.
    logic [ACC_W+3:0]  acc_prod;
    logic [ACC_W-1:0]  acc_step;
    logic [FRAC_W+3:0] frac_prod;

    assign acc_prod  = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1) + (ACC_W+4)'(digit);
    assign acc_step  = (acc_prod > {4'd0, ACC_CAP}) ? ACC_CAP : acc_prod[ACC_W-1:0];
    assign frac_prod = ({4'd0, frac_reg} << 3) + ({4'd0, frac_reg} << 1) + (FRAC_W+4)'(digit);

    logic   used;
    phase_t phase_next;
    logic   neg_next;

    always_comb begin
        used       = 1'b0;
        phase_next = phase_reg;
        neg_next   = neg_reg;
        unique case (phase_reg) inside
            PH_PRE, PH_SIGNED, PH_INT: begin
                if (phase_reg == PH_PRE && is_blank) begin
                    used = 1'b1;
                end else if (phase_reg == PH_PRE && is_sign) begin
                    used       = 1'b1;
                    neg_next   = (char_reg == CH_MINUS);
                    phase_next = PH_SIGNED;
                end else if (is_digit) begin
                    used       = 1'b1;
                    phase_next = PH_INT;
                end else if (char_reg == CH_POINT && fixed) begin
                    used       = 1'b1;
                    phase_next = PH_FRAC;
                end
            end
            PH_FRAC: begin
                used = is_digit;
            end
            default: begin
                used = 1'b0;
            end
        endcase
    end

    // Fraction scaling: q = (frac * 2^FRAC_BITS + p/2) / p. The part of p/2 above
    // the fraction point is folded into the starting remainder, the rest is
    // shifted in below it one bit per divider step.
    logic [P_W-1:0]           p_now;
    logic [P_W+FRAC_BITS-1:0] half_wide;
    logic [R_W-1:0]           rem_init;
    logic [R_W-1:0]           trial;
    logic                     trial_ge;

    assign p_now     = P_W'(pow10(4'(dig_reg)));
    assign half_wide = {{FRAC_BITS{1'b0}}, p_now} >> 1;
    assign rem_init  = R_W'(frac_reg) + R_W'(half_wide[P_W+FRAC_BITS-1:FRAC_BITS]);
    assign trial     = (div_cnt_reg == '0) ? div_rem_reg
                                           : {div_rem_reg[R_W-2:0], div_low_reg[FRAC_BITS-1]};
    assign trial_ge  = trial >= {1'b0, p_reg};

    // Final saturation, sign and masking of a word value.
    logic [47:0] lim;
    logic [47:0] mag_clip;
    logic [47:0] val_signed;
    logic [47:0] val_out;

    always_comb begin
        if (fixed) begin
            lim = neg_reg ? LIM_FIX_NEG : LIM_FIX_POS;
        end else begin
            lim = neg_reg ? LIM_INT_NEG : LIM_INT_POS;
        end
        mag_clip   = (sat_reg || (mag_reg > lim)) ? lim : mag_reg;
        val_signed = neg_reg ? (48'd0 - mag_clip) : mag_clip;
        if (letter_reg == LTR_G || letter_reg == LTR_M) begin
            val_out = {32'd0, val_signed[15:0]};
        end else if (letter_reg == LTR_T) begin
            val_out = {40'd0, val_signed[7:0]};
        end else begin
            val_out = val_signed;
        end
    end

    logic out_free;
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            active_reg  <= 1'b0;
            letter_reg  <= LTR_G;
            phase_reg   <= PH_IDLE;
            neg_reg     <= 1'b0;
            acc_reg     <= '0;
            frac_reg    <= '0;
            dig_reg     <= '0;
            seen_reg    <= '0;
        end else begin
            if ((state_reg == S_EMIT || state_reg == S_SUM) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        char_reg  <= s_data.char_code;
                        eol_reg   <= s_data.end_of_line;
                        state_reg <= S_CHAR;
                    end
                end
                S_CHAR: begin
                    if (!active_reg) begin
                        state_reg <= S_LETTER;
                    end else if (used) begin
                        phase_reg <= phase_next;
                        neg_reg   <= neg_next;
                        if (phase_reg != PH_FRAC && is_digit) begin
                            acc_reg <= acc_step;
                        end
                        if (phase_reg == PH_FRAC &&
                            dig_reg < DIG_W'(MAX_FRAC_DIGITS)) begin
                            frac_reg <= frac_prod[FRAC_W-1:0];
                            dig_reg  <= dig_reg + 1'b1;
                        end
                        state_reg <= S_EOL;
                    end else begin
                        from_eol_reg <= 1'b0;
                        state_reg    <= S_FIN;
                    end
                end
                S_LETTER: begin
                    if (hit.found) begin
                        active_reg <= 1'b1;
                        letter_reg <= hit.code;
                        phase_reg  <= PH_PRE;
                        neg_reg    <= 1'b0;
                        acc_reg    <= '0;
                        frac_reg   <= '0;
                        dig_reg    <= '0;
                        seen_reg   <= seen_reg | (16'd1 << hit.code);
                    end
                    state_reg <= S_EOL;
                end
                S_EOL: begin
                    if (!eol_reg) begin
                        state_reg <= S_IDLE;
                    end else if (active_reg) begin
                        from_eol_reg <= 1'b1;
                        state_reg    <= S_FIN;
                    end else begin
                        state_reg <= S_SUM;
                    end
                end
                S_FIN: begin
                    if (fixed) begin
                        p_reg       <= p_now;
                        div_rem_reg <= rem_init;
                        div_low_reg <= half_wide[FRAC_BITS-1:0];
                        div_cnt_reg <= '0;
                        state_reg   <= S_DIV;
                    end else begin
                        mag_reg   <= 48'(acc_reg);
                        sat_reg   <= 1'b0;
                        state_reg <= S_EMIT;
                    end
                end
                S_DIV: begin
                    div_rem_reg <= trial_ge ? (trial - {1'b0, p_reg}) : trial;
                    quot_reg    <= {quot_reg[Q_W-2:0], trial_ge};
                    if (div_cnt_reg != '0) begin
                        div_low_reg <= div_low_reg << 1;
                    end
                    if (div_cnt_reg == CNT_W'(FRAC_BITS)) begin
                        state_reg <= S_ADD;
                    end else begin
                        div_cnt_reg <= div_cnt_reg + 1'b1;
                    end
                end
                S_ADD: begin
                    // Anything at or above bit 47 after the shift saturates outright.
                    sat_reg   <= |(acc_reg >> HI_LSB);
                    mag_reg   <= {1'b0, acc_reg[HI_LSB-1:0], {FRAC_BITS{1'b0}}} +
                                 48'(quot_reg);
                    state_reg <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_data_reg.kind        <= KIND_WORD;
                        m_data_reg.letter      <= letter_reg;
                        m_data_reg.word_value  <= val_out;
                        m_data_reg.seen_mask   <= '0;
                        m_data_reg.has_command <= 1'b0;
                        // A summary always follows on the line's last character.
                        m_data_reg.last        <= !from_eol_reg && !eol_reg;
                        active_reg             <= 1'b0;
                        phase_reg              <= PH_IDLE;
                        state_reg              <= from_eol_reg ? S_SUM : S_LETTER;
                    end
                end
                S_SUM: begin
                    if (out_free) begin
                        m_data_reg.kind        <= KIND_SUMMARY;
                        m_data_reg.letter      <= LTR_G;
                        m_data_reg.word_value  <= '0;
                        m_data_reg.seen_mask   <= seen_reg;
                        m_data_reg.has_command <= |seen_reg[2:0];
                        m_data_reg.last        <= 1'b1;
                        active_reg             <= 1'b0;
                        letter_reg             <= LTR_G;
                        phase_reg              <= PH_IDLE;
                        neg_reg                <= 1'b0;
                        acc_reg                <= '0;
                        frac_reg               <= '0;
                        dig_reg                <= '0;
                        seen_reg               <= '0;
                        state_reg              <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready = aresetn && (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_acc_capped: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_reg <= ACC_CAP)
        else $error("integer accumulator above its cap");

    a_frac_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        dig_reg <= DIG_W'(MAX_FRAC_DIGITS))
        else $error("too many fraction digits kept");

    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV && div_cnt_reg != '0) |-> (div_rem_reg < {1'b0, p_reg}))
        else $error("divider remainder not below divisor");

    a_summary_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.kind == KIND_SUMMARY) |->
            (m_data.last && m_data.word_value == '0))
        else $error("summary result malformed");

endmodule

`default_nettype wire
